FILE: rtl/core/shmu_pkg.sv
`timescale 1ns / 1ps

package shmu_pkg;

  // diffusion multiplier and lane start constants
  localparam logic [63:0] MixMult = 64'h6eed0e9da4d94a4f;
  localparam logic [63:0] StartA  = 64'h16f11fe89b0d677c;
  localparam logic [63:0] StartB  = 64'hb480a793d8e6c86c;
  localparam logic [63:0] StartC  = 64'h6fe2e5aaf078ebc9;
  localparam logic [63:0] StartD  = 64'h14f994a4c5259381;

  localparam logic [3:0] FullWord = 4'd8;

  // result buffer in the back end
  localparam int OutDepth = 16;
  localparam int OutAw    = 4;

  // one classified request handed from front to back
  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  lane;
    logic        fresh;
    logic        write;
    logic        last;
    logic [31:0] total;
    logic [3:0]  used;
  } req_t;

  // sideband carried next to the lane mixer
  typedef struct packed {
    logic [1:0]  lane;
    logic        write;
    logic        last;
    logic [31:0] total;
    logic [3:0]  used;
  } tag_t;

  function automatic logic [63:0] lane_start(input logic [1:0] lane,
                                             input logic [31:0] seed_v);
    logic [63:0] v;
    case (lane)
      2'd0: v = StartA ^ {32'd0, seed_v};
      2'd1: v = StartB;
      2'd2: v = StartC;
      2'd3: v = StartD;
      default: v = StartA;
    endcase
    return v;
  endfunction

  // keeps the low cnt bytes, cnt already limited to eight
  function automatic logic [63:0] pad_mask(input logic [3:0] cnt);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (4'(b) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/seahash_message_hash_unit.sv
`timescale 1ns / 1ps
// a closing word passes queue, lane mixer, fold and final mixer into the result buffer
// throughput: one message word per cycle unless stalled; a lane is reused every 4 words,
//   matching the multiply, xor-shift, multiply loop of the lane mixer
// a 16-entry result buffer lets back-to-back short messages run at one word per cycle
// reset (synchronous, active high) clears the seed, message position and both queues

module seahash_message_hash_unit import shmu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // message word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  // seed register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed,
  // hash result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_value
);

  // the seed port is always able to take a request
  logic cfg_wr;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // front end: saturates the count, pads the word, picks the lane and keeps the
  // running byte total and the set of lanes already used by this message
  logic q_push;
  req_t q_req;
  logic q_full;
  logic q_valid;
  req_t q_head;
  logic q_pop;

  shmu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .cfg_wr     (cfg_wr),
    .q_push     (q_push),
    .q_req      (q_req),
    .q_full     (q_full)
  );

  // two-entry request queue so the front keeps taking words while the back
  // waits for room in its result buffer
  shmu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (q_req),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  // back end: lane mixer, lane registers, final fold and mix, result buffer
  shmu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_wr     (cfg_wr),
    .cfg_seed   (seed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

`ifndef SYNTHESIS
  // no hash can come out within the pipeline depth after a reset
  a_reset_quiet: assert property (@(posedge clk)
    out_valid |-> (!$past(rst, 1) && !$past(rst, 4) && !$past(rst, 8)))
    else $error("hash offered too soon after reset");

  // a full queue must present a request to the back end
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    q_full |-> q_valid)
    else $error("request queue full but empty at head");

  // empty words only travel to the back end when they close a message
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_req.write) |-> q_req.last)
    else $error("empty non-final word queued");
`endif

endmodule

FILE: rtl/core/shmu_front.sv
`timescale 1ns / 1ps

module shmu_front import shmu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  input  logic        cfg_wr,
  output logic        q_push,
  output req_t        q_req,
  input  logic        q_full
);

  logic [1:0]  ptr;
  logic [31:0] total;
  logic [3:0]  used;

  logic        accept;
  logic [3:0]  cnt;
  logic        wr;
  logic [3:0]  lane_bit;
  logic [31:0] total_next;
  logic [3:0]  used_next;

  always_comb begin
    accept     = in_valid && !q_full;
    cnt        = (byte_count > FullWord) ? FullWord : byte_count;
    wr         = (cnt != 4'd0);
    lane_bit   = 4'b0001 << ptr;
    total_next = total + {28'd0, cnt};
    used_next  = wr ? (used | lane_bit) : used;

    in_stall = q_full;
    // empty words that do not close a message carry nothing to the back end
    q_push = accept && (wr || last_word);

    q_req.word  = data_word & pad_mask(cnt);
    q_req.lane  = ptr;
    q_req.fresh = !used[ptr];
    q_req.write = wr;
    q_req.last  = last_word;
    q_req.total = total_next;
    q_req.used  = used_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      ptr   <= 2'd0;
      total <= 32'd0;
      used  <= 4'd0;
    end else if (accept) begin
      if (last_word) begin
        ptr   <= 2'd0;
        total <= 32'd0;
        used  <= 4'd0;
      end else if (wr) begin
        ptr   <= ptr + 2'd1;
        total <= total_next;
        used  <= used_next;
      end
    end
  end

endmodule

FILE: rtl/core/shmu_queue.sv
`timescale 1ns / 1ps

module shmu_queue import shmu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  output logic valid,
  output req_t head,
  input  logic pop
);

  req_t       slot [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign head  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_req;
    end
  end

endmodule

FILE: rtl/core/shmu_mix.sv
`timescale 1ns / 1ps

module shmu_mix import shmu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [63:0] out_value
);

  // low 64 bits of v * MixMult from three 32x32 partial products
  logic [63:0] pll_d, pll_q, pll2_d, pll2_q;
  logic [31:0] plh_d, plh_q, plh2_d, plh2_q;
  logic [31:0] phl_d, phl_q, phl2_d, phl2_q;
  logic [63:0] sum1;
  logic [63:0] xs_d, xs_q;
  logic        v1, v2, v3;

  always_comb begin
    pll_d = {32'd0, in_value[31:0]} * {32'd0, MixMult[31:0]};
    plh_d = in_value[31:0] * MixMult[63:32];
    phl_d = in_value[63:32] * MixMult[31:0];

    sum1 = pll_q + {plh_q + phl_q, 32'd0};
    xs_d = sum1 ^ ((sum1 >> 32) >> sum1[63:60]);

    pll2_d = {32'd0, xs_q[31:0]} * {32'd0, MixMult[31:0]};
    plh2_d = xs_q[31:0] * MixMult[63:32];
    phl2_d = xs_q[63:32] * MixMult[31:0];

    out_value = pll2_q + {plh2_q + phl2_q, 32'd0};
    out_valid = v3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    xs_q   <= xs_d;
    pll2_q <= pll2_d;
    plh2_q <= plh2_d;
    phl2_q <= phl2_d;
  end

endmodule

FILE: rtl/core/shmu_back.sv
`timescale 1ns / 1ps

module shmu_back import shmu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  req_t        q_head,
  output logic        q_pop,
  input  logic        cfg_wr,
  input  logic [31:0] cfg_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_value
);

  logic [31:0]      seed_q;
  logic [63:0]      lanes [4];
  logic [OutAw:0]   credits;
  logic             issue;
  logic             pop_out;

  logic [63:0]      base;
  logic [63:0]      mix_in;
  logic             mix_ov;
  logic [63:0]      mix_out;
  tag_t             tag_d, tag1, tag2, tag3;

  logic             fin_pend;
  logic [31:0]      fin_total;
  logic [3:0]       fin_used;
  logic [63:0]      fold;
  logic             fin_valid;
  logic [63:0]      fin_value;
  logic             hash_ov;
  logic [63:0]      hash_out;

  logic [63:0]      ofifo [OutDepth];
  logic [OutAw-1:0] owp, orp;
  logic [OutAw:0]   ocnt;

  always_comb begin
    // a closing request needs room reserved in the result buffer
    issue = q_valid && (!q_head.last || (credits < (OutAw+1)'(OutDepth)));
    q_pop = issue;

    base   = q_head.fresh ? lane_start(q_head.lane, seed_q) : lanes[q_head.lane];
    mix_in = base ^ q_head.word;

    tag_d.lane  = q_head.lane;
    tag_d.write = q_head.write;
    tag_d.last  = q_head.last;
    tag_d.total = q_head.total;
    tag_d.used  = q_head.used;

    // lanes not touched by the message still count as their start values
    fold = {32'd0, fin_total};
    for (int i = 0; i < 4; i++) begin
      fold = fold ^ (fin_used[i] ? lanes[i] : lane_start(2'(i), seed_q));
    end

    out_valid  = (ocnt != '0);
    hash_value = ofifo[orp];
    pop_out    = out_valid && !out_stall;
  end

  shmu_mix u_lane_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue),
    .in_value  (mix_in),
    .out_valid (mix_ov),
    .out_value (mix_out)
  );

  shmu_mix u_fin_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fin_valid),
    .in_value  (fin_value),
    .out_valid (hash_ov),
    .out_value (hash_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_q    <= 32'd0;
      fin_pend  <= 1'b0;
      fin_valid <= 1'b0;
      credits   <= '0;
      owp       <= '0;
      orp       <= '0;
      ocnt      <= '0;
    end else begin
      if (cfg_wr) begin
        seed_q <= cfg_seed;
      end
      fin_pend  <= mix_ov && tag3.last;
      fin_valid <= fin_pend;
      if (hash_ov) begin
        owp <= owp + 1'b1;
      end
      if (pop_out) begin
        orp <= orp + 1'b1;
      end
      case ({hash_ov, pop_out})
        2'b10:   ocnt <= ocnt + 1'b1;
        2'b01:   ocnt <= ocnt - 1'b1;
        default: ocnt <= ocnt;
      endcase
      case ({issue && q_head.last, pop_out})
        2'b10:   credits <= credits + 1'b1;
        2'b01:   credits <= credits - 1'b1;
        default: credits <= credits;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= tag_d;
    tag2 <= tag1;
    tag3 <= tag2;
    if (mix_ov && tag3.write) begin
      lanes[tag3.lane] <= mix_out;
    end
    fin_total <= tag3.total;
    fin_used  <= tag3.used;
    fin_value <= fold;
    if (hash_ov) begin
      ofifo[owp] <= hash_out;
    end
  end

endmodule
